// ===== rtl/sfla_pkg.sv =====
`timescale 1ns / 1ps
package sfla_pkg;
  localparam int MemWords  = 1024;
  localparam int FreeSlots = 16;
  localparam int SegIds    = 16;
  localparam int AW = 11;
  localparam int CW = $clog2(FreeSlots + 1);
  localparam int IW = $clog2(SegIds);

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOFIT = 2'd1, ST_BADID = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_INIT, OP_DEL, OP_INS, OP_SET
  } cop_t;

  // command broadcast to every cell in the row
  typedef struct packed {
    cop_t          op;
    logic [CW-1:0] pos;
    logic [AW-1:0] base;
    logic [AW-1:0] len;
  } cell_cmd_t;

  typedef struct packed {
    logic [AW-1:0] base;
    logic [AW-1:0] len;
  } seg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT, S_OUT
  } state_t;
endpackage

// ===== rtl/sfla_if.sv =====
`timescale 1ns / 1ps
interface sfla_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  seg_id;
  logic [9:0]  seg_start;
  logic [10:0] seg_size;
  modport source (output valid, func, seg_id, seg_start, seg_size, input ready);
  modport sink   (input valid, func, seg_id, seg_start, seg_size, output ready);
endinterface

interface sfla_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

interface sfla_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/segment_free_list_allocator_core.sv =====
`timescale 1ns / 1ps
// Segment allocator with a sorted free list held in a row of cells.
// Channels: in (func, seg_id, seg_start, seg_size), out (status) and cfg
// (memory size in words). All use valid/ready; an item moves when both are high.
// A create claims an exact range that must sit in one free segment; a
// remove returns a segment and merges it with its free neighbours.
// After the item is taken, the free list is scanned slot by slot, then up
// to two list edits are issued; the status is then held in the output
// register until taken.
// One item is handled at a time; a new item is taken once the status has
// been taken, so a stalled receiver holds off the input.
// Reset (rst_n, synchronous, active low) leaves one free segment of 1024
// words and no segments allocated. A cfg write reloads the free list and
// clears all allocations.
module segment_free_list_allocator_core (
  input logic clk,
  input logic rst_n,
  sfla_in_if.sink    in_ch,
  sfla_out_if.source out_ch,
  sfla_cfg_if.sink   cfg_ch
);
  import sfla_pkg::*;

  cell_cmd_t     cmd, cmd_mux;
  seg_t          q [FreeSlots];
  seg_t          rd;
  logic [CW-1:0] rd_idx;

  // reset reloads the list like a cfg write of the full size
  always_comb begin
    cmd_mux = cmd;
    if (!rst_n) cmd_mux = '{op: OP_INIT, pos: '0, base: '0, len: AW'(MemWords)};
  end

  assign rd = (rd_idx < CW'(FreeSlots)) ? q[rd_idx[$clog2(FreeSlots)-1:0]] : '0;

  sfla_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .cfg_ch, .rd, .rd_idx, .cmd
  );

  for (genvar g = 0; g < FreeSlots; g++) begin : g_cell
    sfla_cell u_cell (
      .clk,
      .idx   (CW'(g)),
      .cmd   (cmd_mux),
      .left  ((g == 0) ? seg_t'('0) : q[(g == 0) ? 0 : g - 1]),
      .right ((g == FreeSlots - 1) ? seg_t'('0) : q[(g == FreeSlots - 1) ? g : g + 1]),
      .q     (q[g])
    );
  end
endmodule

// ===== rtl/sfla_cell.sv =====
`timescale 1ns / 1ps
module sfla_cell (
  input  logic               clk,
  input  logic [sfla_pkg::CW-1:0] idx,
  input  sfla_pkg::cell_cmd_t cmd,
  input  sfla_pkg::seg_t     left,
  input  sfla_pkg::seg_t     right,
  output sfla_pkg::seg_t     q
);
  import sfla_pkg::*;
  seg_t q_r;
  assign q = q_r;

  // shift left on delete, right on insert, load at the target slot
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_INIT: begin
        q_r.base <= '0;
        q_r.len  <= (idx == '0) ? cmd.len : '0;
      end
      OP_DEL: if (idx >= cmd.pos) q_r <= right;
      OP_INS: begin
        if (idx == cmd.pos) q_r <= '{base: cmd.base, len: cmd.len};
        else if (idx > cmd.pos) q_r <= left;
      end
      OP_SET: if (idx == cmd.pos) q_r <= '{base: cmd.base, len: cmd.len};
      default: ;
    endcase
  end
endmodule

// ===== rtl/sfla_ctrl.sv =====
`timescale 1ns / 1ps
module sfla_ctrl (
  input  logic clk,
  input  logic rst_n,
  sfla_in_if.sink   in_ch,
  sfla_out_if.source out_ch,
  sfla_cfg_if.sink  cfg_ch,
  input  sfla_pkg::seg_t rd,
  output logic [sfla_pkg::CW-1:0] rd_idx,
  output sfla_pkg::cell_cmd_t cmd
);
  import sfla_pkg::*;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, p_r, p_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic          func_r;
  logic [IW-1:0] id_r;
  logic [AW-1:0] start_r, size_r;
  logic [AW:0]   end_r;
  logic          found_r, found_nxt, mprev_r, mprev_nxt;
  seg_t          hit_r, hit_nxt, prv_r, prv_nxt, nxt_r, nxt_nxt;
  logic          nxtv_r, nxtv_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [SegIds-1:0] av_r;
  logic [AW-2:0] abase_m [SegIds];
  logic [AW-1:0] alen_m  [SegIds];
  logic [AW-1:0] abase_r, alen_r;
  logic [AW-1:0] tot;
  logic          aset, aclr;
  logic [AW-1:0] fend, end_w;
  logic          step2_r, step2_nxt;

  assign tot = (cfg_ch.data > AW'(MemWords)) ? AW'(MemWords) : cfg_ch.data;
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.status = st_r;
  assign rd_idx = cnt_r;
  assign fend = rd.base + rd.len;
  // a range that fits never ends past the memory, so the low bits suffice
  assign end_w = end_r[AW-1:0];

  // allocation table memory, read once when the item is taken
  always_ff @(posedge clk) begin
    if (aset) begin
      abase_m[id_r] <= start_r[AW-2:0];
      alen_m[id_r]  <= size_r;
    end
    if (in_ch.valid && in_ch.ready) begin
      abase_r <= {1'b0, abase_m[in_ch.seg_id]};
      alen_r  <= alen_m[in_ch.seg_id];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      av_r    <= '0;
      fcnt_r  <= CW'(1);
    end else begin
      state_r <= state_nxt;
      fcnt_r  <= fcnt_nxt;
      if (cfg_ch.valid && cfg_ch.ready) av_r <= '0;
      else if (aset) av_r[id_r] <= 1'b1;
      else if (aclr) av_r[id_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt; p_r <= p_nxt; found_r <= found_nxt; mprev_r <= mprev_nxt;
    hit_r <= hit_nxt; prv_r <= prv_nxt; nxt_r <= nxt_nxt; nxtv_r <= nxtv_nxt;
    st_r <= st_nxt; step2_r <= step2_nxt;
    if (in_ch.valid && in_ch.ready) begin
      func_r  <= in_ch.func;
      id_r    <= in_ch.seg_id;
      start_r <= {1'b0, in_ch.seg_start};
      size_r  <= in_ch.seg_size;
      end_r   <= {2'b00, in_ch.seg_start} + {1'b0, in_ch.seg_size};
    end
  end

  // sequencer: scan the row one slot a cycle, then issue up to two edits
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; p_nxt = p_r; found_nxt = found_r;
    mprev_nxt = mprev_r; hit_nxt = hit_r; prv_nxt = prv_r; nxt_nxt = nxt_r;
    nxtv_nxt = nxtv_r; st_nxt = st_r; step2_nxt = step2_r;
    fcnt_nxt = fcnt_r; aset = 1'b0; aclr = 1'b0;
    cmd = '{op: OP_NONE, pos: '0, base: '0, len: '0};
    unique case (state_r)
      S_IDLE: begin
        if (cfg_ch.valid) begin
          cmd = '{op: OP_INIT, pos: '0, base: '0, len: tot};
          fcnt_nxt = (tot == '0) ? '0 : CW'(1);
        end else if (in_ch.valid) begin
          cnt_nxt = '0; found_nxt = 1'b0; mprev_nxt = 1'b0; nxtv_nxt = 1'b0;
          step2_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (func_r == 1'b0) begin
          if (size_r == '0) begin
            st_nxt = ST_NOFIT; state_nxt = S_OUT;
          end else if (cnt_r >= fcnt_r) begin
            st_nxt = ST_NOFIT; state_nxt = S_OUT;
          end else if (rd.base <= start_r && {1'b0, fend} >= end_r) begin
            p_nxt = cnt_r; hit_nxt = rd; state_nxt = S_ACT;
          end else cnt_nxt = cnt_r + 1'b1;
        end else begin
          if (!av_r[id_r]) begin
            st_nxt = ST_BADID; state_nxt = S_OUT;
          end else if (cnt_r < fcnt_r && rd.base < abase_r) begin
            prv_nxt = rd; mprev_nxt = (fend == abase_r);
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            p_nxt = cnt_r;
            nxtv_nxt = (cnt_r < fcnt_r) && (abase_r + alen_r == rd.base);
            nxt_nxt = rd;
            state_nxt = S_ACT;
          end
        end
      end
      S_ACT: begin
        st_nxt = ST_OK; state_nxt = S_OUT;
        if (func_r == 1'b0) begin
          if (hit_r.base == start_r && hit_r.base + hit_r.len == end_w) begin
            cmd = '{op: OP_DEL, pos: p_r, base: '0, len: '0};
            fcnt_nxt = fcnt_r - 1'b1; aset = 1'b1;
          end else if (hit_r.base == start_r) begin
            cmd = '{op: OP_SET, pos: p_r, base: hit_r.base + size_r,
                    len: hit_r.len - size_r};
            aset = 1'b1;
          end else if (hit_r.base + hit_r.len == end_w) begin
            cmd = '{op: OP_SET, pos: p_r, base: hit_r.base, len: hit_r.len - size_r};
            aset = 1'b1;
          end else if (!step2_r && fcnt_r >= CW'(FreeSlots)) begin
            st_nxt = ST_FULL;
          end else if (!step2_r) begin
            cmd = '{op: OP_INS, pos: p_r + 1'b1, base: end_w,
                    len: hit_r.base + hit_r.len - end_w};
            fcnt_nxt = fcnt_r + 1'b1; step2_nxt = 1'b1; state_nxt = S_ACT;
          end else begin
            cmd = '{op: OP_SET, pos: p_r, base: hit_r.base,
                    len: start_r - hit_r.base};
            aset = 1'b1;
          end
        end else begin
          if (mprev_r && nxtv_r) begin
            if (!step2_r) begin
              cmd = '{op: OP_SET, pos: p_r - 1'b1, base: prv_r.base,
                      len: prv_r.len + alen_r + nxt_r.len};
              step2_nxt = 1'b1; state_nxt = S_ACT;
            end else begin
              cmd = '{op: OP_DEL, pos: p_r, base: '0, len: '0};
              fcnt_nxt = fcnt_r - 1'b1; aclr = 1'b1;
            end
          end else if (mprev_r) begin
            cmd = '{op: OP_SET, pos: p_r - 1'b1, base: prv_r.base,
                    len: prv_r.len + alen_r};
            aclr = 1'b1;
          end else if (nxtv_r) begin
            cmd = '{op: OP_SET, pos: p_r, base: abase_r, len: nxt_r.len + alen_r};
            aclr = 1'b1;
          end else if (fcnt_r >= CW'(FreeSlots)) begin
            st_nxt = ST_FULL;
          end else begin
            cmd = '{op: OP_INS, pos: p_r, base: abase_r, len: alen_r};
            fcnt_nxt = fcnt_r + 1'b1; aclr = 1'b1;
          end
        end
      end
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // mprev only counts if the last scanned entry was directly before p
    if (state_r == S_SCAN && func_r && av_r[id_r] &&
        cnt_r < fcnt_r && rd.base < abase_r) mprev_nxt = (fend == abase_r);
  end
endmodule

// ===== rtl/sfla_chk.sv =====
`timescale 1ns / 1ps
module sfla_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic cfg_valid,
  input logic cfg_ready
);
  // one item in flight: no input taken while a status waits
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while busy");
  // an accepted item is not answered in the cycle after it is taken
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("answer too early");
  // held status stays stable under stall
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_status))
    else $error("status dropped");
  // no cfg write while a status waits
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !cfg_ready) else $error("cfg during item");
  // a cfg write produces no status
  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !out_valid) else $error("status after cfg");
endmodule

bind segment_free_list_allocator_core sfla_chk u_chk (
  .clk, .rst_n,
  .in_valid (in_ch.valid), .in_ready (in_ch.ready),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_status (out_ch.status),
  .cfg_valid (cfg_ch.valid), .cfg_ready (cfg_ch.ready)
);
